/* rtl/e8sd_pkg.sv */
// e8sd_pkg: shared widths, constants and the EAN-8 L-code table
// for the EAN-8 scanline decoder; no dependencies
`default_nettype none

package e8sd_pkg;

	// line geometry
	localparam int MAX_LINE_PIXELS = 4096;
	localparam int COL_W = $clog2(MAX_LINE_PIXELS) + 1;
	localparam int EDGE_W = 12;
	localparam int MW_W = 6;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 2;

	// five-pixel sum threshold: an average of 129 or more (sum 645) reads as light
	localparam logic [10:0] SUM_THRESHOLD = 11'd645;

	// bit positions of the two halves
	localparam logic [6:0] LEFT_FIRST = 7'd3;
	localparam logic [6:0] LEFT_LAST = 7'd30;
	localparam logic [6:0] RIGHT_FIRST = 7'd36;
	localparam logic [6:0] RIGHT_LAST = 7'd63;
	localparam logic [6:0] BIT_COUNT_MAX = 7'd127;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_EDGE = 2'd0,
		CFG_RIGHT_EDGE = 2'd1,
		CFG_MODULE_WIDTH = 2'd2
	} cfg_idx_t;

	// L-code patterns of digits 0..9
	typedef logic [6:0] code_t;
	localparam code_t LCODE [10] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};

	// result of matching one 7-bit group
	typedef struct packed {
		logic [3:0] value;
		logic matched;
	} match_t;

endpackage

`default_nettype wire

/* rtl/ean8_scanline_decoder_top.sv */
// ean8_scanline_decoder_top: pixel stream in, decoded EAN-8 digits out
// depends on e8sd_pkg and e8sd_code_match
`default_nettype none

// One pixel transaction per clock is accepted and one digit transaction is
// produced for every completed 7-bit group, up to eight per scanline. A pixel goes
// through an input register and the line state update into the result
// register, which holds the digit on the output until it is taken.
// The input stalls only while a digit waits in the result register
// under an output stall and the pixel in the input register makes another.
// Sample points sit at left_edge + module_width/2 and every module_width
// pixels after, below right_edge; each is decided from the five pixels centred
// on it, when the pixel two columns to its right arrives. line_start (or the
// first pixel after reset) begins a line; left_edge takes effect at line begin.
// Configuration is to be written only while no pixel is in flight; the block does not enforce it.
module ean8_scanline_decoder_top
	import e8sd_pkg::*;
(
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	// configuration write port
	input  wire  logic                  cfg_write,
	input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel channel
	input  wire  logic                  in_valid,
	output logic                        in_stall,
	input  wire  logic [7:0]            pixel_red,
	input  wire  logic                  line_start,
	// digit channel
	output logic                        out_valid,
	input  wire  logic                  out_stall,
	output logic [3:0]                  digit_value,
	output logic                        digit_matched,
	output logic [2:0]                  digit_index,
	output logic                        last_digit
);

	// configuration registers
	logic [EDGE_W-1:0] left_edge_q;
	logic [EDGE_W-1:0] right_edge_q;
	logic [MW_W-1:0]   module_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q <= '0;
			right_edge_q <= '1;
			module_width_q <= MW_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LEFT_EDGE:    left_edge_q <= cfg_data[EDGE_W-1:0];
				CFG_RIGHT_EDGE:   right_edge_q <= cfg_data[EDGE_W-1:0];
				CFG_MODULE_WIDTH: module_width_q <= cfg_data[MW_W-1:0];
				default:          ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] pixel_s1;
	logic       start_s1;
	logic       advance;
	logic       in_take;

	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pixel_s1 <= pixel_red;
			start_s1 <= line_start;
		end
	end

	// line state
	logic [COL_W-1:0] pixel_column_q;
	logic [7:0]       window_q [4];
	logic [COL_W-1:0] next_sample_q;
	logic [6:0]       bit_count_q;
	code_t            group_bits_q;
	logic [3:0]       digits_done_q;

	// effective state after a possible line begin
	logic             line_begin;
	logic             line_over;
	logic [COL_W-1:0] col_e;
	logic [7:0]       win_e [4];
	logic [COL_W-1:0] next_e;
	logic [6:0]       bc_e;
	code_t            gb_e;
	logic [3:0]       dd_e;

	assign line_begin = start_s1 || (pixel_column_q == '0);
	assign line_over = !line_begin && (pixel_column_q >= COL_W'(MAX_LINE_PIXELS));

	always_comb begin
		col_e = line_begin ? '0 : pixel_column_q;
		next_e = line_begin ? (COL_W'(left_edge_q) + COL_W'(module_width_q >> 1))
		                    : next_sample_q;
		bc_e = line_begin ? '0 : bit_count_q;
		gb_e = line_begin ? '0 : group_bits_q;
		dd_e = line_begin ? '0 : digits_done_q;
		for (int i = 0; i < 4; i++) begin
			win_e[i] = line_begin ? '0 : window_q[i];
		end
	end

	// sample decision
	logic              sample;
	logic [10:0]       sum;
	logic              bit_val;
	logic              in_left;
	logic              in_right;
	logic [4:0]        off;
	logic [1:0]        grp;
	logic [4:0]        rem;
	logic              group_done;
	code_t             gb_next;
	logic              produce;
	match_t            match;

	assign sample = (next_e < COL_W'(right_edge_q))
	             && ({1'b0, col_e} == ({1'b0, next_e} + (COL_W+1)'(2)));
	assign sum = 11'(win_e[0]) + 11'(win_e[1]) + 11'(win_e[2]) + 11'(win_e[3])
	           + 11'(pixel_s1);
	assign bit_val = (sum < SUM_THRESHOLD);
	assign in_left = (bc_e >= LEFT_FIRST) && (bc_e <= LEFT_LAST);
	assign in_right = (bc_e >= RIGHT_FIRST) && (bc_e <= RIGHT_LAST);

	// offset within the half, split into group number and position
	always_comb begin
		off = in_left ? 5'(bc_e - LEFT_FIRST) : 5'(bc_e - RIGHT_FIRST);
		grp = 2'(off >= 5'd7) + 2'(off >= 5'd14) + 2'(off >= 5'd21);
		rem = off - 5'(7 * grp);
	end

	assign gb_next = {gb_e[5:0], bit_val};
	assign group_done = sample && (in_left || in_right) && (rem == 5'd6);
	assign produce = valid_s1 && !line_over && group_done;

	e8sd_code_match u_match (
		.group_bits (gb_next),
		.right_half (in_right),
		.result     (match)
	);

	// s1 moves on unless it makes a digit that has nowhere to go
	assign advance = valid_s1 && (!produce || !out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_column_q <= '0;
			next_sample_q <= '0;
			bit_count_q <= '0;
			group_bits_q <= '0;
			digits_done_q <= '0;
			for (int i = 0; i < 4; i++) begin
				window_q[i] <= '0;
			end
		end else if (advance && !line_over) begin
			pixel_column_q <= col_e + COL_W'(1);
			window_q[0] <= win_e[1];
			window_q[1] <= win_e[2];
			window_q[2] <= win_e[3];
			window_q[3] <= pixel_s1;
			next_sample_q <= sample ? (next_e + COL_W'(module_width_q)) : next_e;
			bit_count_q <= (sample && bc_e != BIT_COUNT_MAX) ? bc_e + 7'd1 : bc_e;
			if (group_done) begin
				group_bits_q <= '0;
				digits_done_q <= dd_e + 4'd1;
			end else begin
				group_bits_q <= (sample && (in_left || in_right)) ? gb_next : gb_e;
				digits_done_q <= dd_e;
			end
		end
	end

	// result register
	logic [2:0] idx;

	assign idx = {in_right, grp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && produce) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			digit_value <= match.value;
			digit_matched <= match.matched;
			digit_index <= idx;
			last_digit <= (idx == 3'd7);
		end
	end

endmodule

`default_nettype wire

/* rtl/e8sd_code_match.sv */
// e8sd_code_match: matches one 7-bit group against the L-code table,
// inverting first for the right half (R-code); uses e8sd_pkg
`default_nettype none

module e8sd_code_match
	import e8sd_pkg::*;
(
	input  wire code_t  group_bits,
	input  wire logic   right_half,
	output match_t      result
);

	code_t pattern;

	// R-code is the bitwise complement of L-code
	assign pattern = right_half ? ~group_bits : group_bits;

	// table search over the ten codes, the lowest matching digit wins
	always_comb begin
		result = '0;
		for (int d = 9; d >= 0; d--) begin
			if (LCODE[d] == pattern) begin
				result.value = 4'(d);
				result.matched = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* dv/ean8_digit_tracker_pkg.sv */
// ean8_digit_tracker_pkg: digit prediction and checking for the scanline decoder bench
// depends on e8sd_pkg for register indexes, constants and the L-code table
`timescale 1ns / 100ps

package ean8_digit_tracker_pkg;

	import e8sd_pkg::*;

	// one decoded digit as seen on the output channel
	typedef struct packed {
		logic [3:0] value;
		logic       matched;
		logic [2:0] position;
		logic       last;
	} digit_t;

	// follows the line state pixel by pixel and holds the digits still due
	class ean8_digit_tracker;

		// register copies, reset values
		logic [11:0] left_edge = 12'd0;
		logic [11:0] right_edge = 12'd4095;
		logic [5:0]  module_width = 6'd1;

		// line state
		logic [12:0] pixel_col = '0;
		logic [7:0]  window [4];
		logic [12:0] next_sample_col = '0;
		logic [6:0]  bit_count = '0;
		logic [6:0]  group_bits = '0;

		digit_t expected_digits [$];
		int     fail_count = 0;

		function new();
			foreach (window[i]) window[i] = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [11:0] data);
			case (idx)
				CFG_LEFT_EDGE: left_edge = data;
				CFG_RIGHT_EDGE: right_edge = data;
				CFG_MODULE_WIDTH: module_width = data[5:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_digits.size();
		endfunction

		// one accepted pixel transaction
		function void note_pixel(logic [7:0] pix, bit start);
			logic [10:0] sum;
			logic        bit_val;
			logic        left_half;
			logic        right_half;
			logic [6:0]  off;
			logic [6:0]  pattern;
			digit_t      d;

			// line begin, or pixels past the end of the line are dropped
			if (start || pixel_col == 0) begin
				pixel_col = '0;
				foreach (window[i]) window[i] = '0;
				next_sample_col = left_edge + (module_width >> 1);
				bit_count = '0;
				group_bits = '0;
			end else if (pixel_col >= MAX_LINE_PIXELS) begin
				return;
			end

			// sample decided two columns right of its centre
			if (next_sample_col < right_edge &&
			    int'(pixel_col) == int'(next_sample_col) + 2) begin
				sum = window[0] + window[1] + window[2] + window[3] + pix;
				bit_val = (sum >= SUM_THRESHOLD) ? 1'b0 : 1'b1;
				left_half = (bit_count >= LEFT_FIRST && bit_count <= LEFT_LAST);
				right_half = (bit_count >= RIGHT_FIRST && bit_count <= RIGHT_LAST);
				if (left_half || right_half) begin
					off = left_half ? bit_count - LEFT_FIRST : bit_count - RIGHT_FIRST;
					group_bits = {group_bits[5:0], bit_val};
					if (off % 7 == 6) begin
						pattern = right_half ? ~group_bits : group_bits;
						d = '0;
						for (int k = 0; k < 10; k++) begin
							if (!d.matched && LCODE[k] == pattern) begin
								d.value = 4'(k);
								d.matched = 1'b1;
							end
						end
						d.position = left_half ? 3'(off / 7) : 3'(4 + off / 7);
						d.last = (d.position == 3'd7);
						expected_digits = {expected_digits, d};
						group_bits = '0;
					end
				end
				if (bit_count != BIT_COUNT_MAX)
					bit_count++;
				next_sample_col = next_sample_col + module_width;
			end

			window[0] = window[1];
			window[1] = window[2];
			window[2] = window[3];
			window[3] = pix;
			pixel_col++;
		endfunction

		// one accepted digit transaction against the oldest expectation
		function void check_digit(digit_t got);
			digit_t want;

			if (expected_digits.size() == 0) begin
				$error("digit transaction with no digit expected: value %0d index %0d",
					got.value, got.position);
				fail_count++;
				return;
			end
			want = expected_digits.pop_front();
			if (got.value !== want.value) begin
				$error("digit_value: expected %0d, got %0d", want.value, got.value);
				fail_count++;
			end
			if (got.matched !== want.matched) begin
				$error("digit_matched: expected %0d, got %0d", want.matched, got.matched);
				fail_count++;
			end
			if (got.position !== want.position) begin
				$error("digit_index: expected %0d, got %0d", want.position, got.position);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last_digit: expected %0d, got %0d", want.last, got.last);
				fail_count++;
			end
		endfunction

	endclass

endpackage

/* dv/ean8_scanline_decoder_top_test.sv */
// ean8_scanline_decoder_top_test: drives pixel lines into the EAN-8 decoder and
// checks every decoded digit; depends on e8sd_pkg and ean8_digit_tracker_pkg
`timescale 1ns / 100ps

module ean8_scanline_decoder_top_test;

	import e8sd_pkg::*;
	import ean8_digit_tracker_pkg::*;

	localparam int RUN_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PIXELS = 400;
	localparam int BARCODE_MODULES = 67;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            pixel_red = '0;
	logic                  line_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [3:0]            digit_value;
	logic                  digit_matched;
	logic [2:0]            digit_index;
	logic                  last_digit;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int random_pixels = 0;

	ean8_digit_tracker tracker = new();

	ean8_scanline_decoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_red(pixel_red),
		.line_start(line_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digit_value(digit_value),
		.digit_matched(digit_matched),
		.digit_index(digit_index),
		.last_digit(last_digit)
	);

	// 20 ns clock
	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	// run limit
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("ean8_scanline_decoder_top_test NOT OK");
		$finish;
	end

	// digit receiver: random stall, or a long hold-off when requested
	initial begin
		digit_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.value = digit_value;
				got.matched = digit_matched;
				got.position = digit_index;
				got.last = last_digit;
				tracker.check_digit(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// one pixel transaction, with random idle cycles ahead of it
	task automatic send_pixel(input logic [7:0] pix, input bit start);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_red <= pix;
		line_start <= start;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_pixel(pix, start);
	endtask

	// stop sending and wait until every digit is out and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers on an idle block
	task automatic configure(input logic [11:0] left, input logic [11:0] right,
		input logic [5:0] mw);
		logic [11:0] mw_data;

		settle();
		mw_data = {6'($urandom_range(63)), mw};
		cfg_write <= 1'b1;
		cfg_index <= CFG_LEFT_EDGE;
		cfg_data <= left;
		@(posedge clk);
		tracker.set_reg(CFG_LEFT_EDGE, left);
		cfg_index <= CFG_RIGHT_EDGE;
		cfg_data <= right;
		@(posedge clk);
		tracker.set_reg(CFG_RIGHT_EDGE, right);
		cfg_index <= CFG_MODULE_WIDTH;
		cfg_data <= mw_data;
		@(posedge clk);
		tracker.set_reg(CFG_MODULE_WIDTH, mw_data);
		cfg_write <= 1'b0;
	endtask

	// scanline holding an EAN-8 bar pattern with random digits
	task automatic send_barcode(input int left, input int mw, input int n);
		bit         dark [BARCODE_MODULES];
		logic [6:0] code;
		bit         is_dark;
		logic [7:0] pix;

		// guards
		dark[0] = 1; dark[1] = 0; dark[2] = 1;
		dark[31] = 0; dark[32] = 1; dark[33] = 0; dark[34] = 1; dark[35] = 0;
		dark[64] = 1; dark[65] = 0; dark[66] = 1;
		// left digits in L-code, right digits in R-code, some garbled
		for (int k = 0; k < 4; k++) begin
			code = LCODE[$urandom_range(9)];
			if ($urandom_range(5) == 0)
				code = 7'($urandom_range(127));
			for (int j = 0; j < 7; j++)
				dark[3 + 7 * k + j] = code[6 - j];
			code = LCODE[$urandom_range(9)];
			if ($urandom_range(5) == 0)
				code = 7'($urandom_range(127));
			for (int j = 0; j < 7; j++)
				dark[36 + 7 * k + j] = !code[6 - j];
		end
		for (int c = 0; c < n; c++) begin
			if (mw == 0 || c < left || c >= left + BARCODE_MODULES * mw)
				is_dark = 0;
			else
				is_dark = dark[(c - left) / mw];
			pix = is_dark ? 8'($urandom_range(85)) : 8'($urandom_range(255, 170));
			if ($urandom_range(199) == 0)
				pix = 8'($urandom_range(255));
			send_pixel(pix, c == 0);
		end
	endtask

	// random pixels, mostly continuing the previous line
	task automatic send_noise(input int n);
		for (int c = 0; c < n; c++)
			send_pixel(8'($urandom_range(255)), $urandom_range(19) == 0);
	endtask

	// stimulus
	initial begin
		logic [7:0] first_line [19] = '{255, 0, 255, 129, 129, 129, 129, 129, 128, 128,
			0, 0, 0, 0, 255, 255, 0, 0, 255};
		int line_no;
		int left;
		int mw;
		int right;
		int n;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first line after reset without line_start, default registers:
		// zero window left of column 0, sums of exactly 645 and 644
		foreach (first_line[i])
			send_pixel(first_line[i], 1'b0);
		// zero module width takes one sample
		configure(12'd0, 12'd4095, 6'd0);
		send_pixel(8'd0, 1'b1);
		for (int i = 0; i < 5; i++)
			send_pixel(8'd255, 1'b0);

		// random lines, idling phase per line
		line_no = 0;
		do begin
			case (line_no % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 82; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 82; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			case (line_no)
				1: begin
					// left edge at the far end: no sample point
					configure(12'd4095, 12'd4095, 6'd2);
					send_barcode(4095, 2, 40);
				end
				3: begin
					// right edge zero: no sample point
					left = $urandom_range(20);
					configure(12'(left), 12'd0, 6'd2);
					send_barcode(left, 2, left + 60);
				end
				4: begin
					// wide module, first few samples of the pattern
					left = $urandom_range(3);
					configure(12'(left), 12'd4095, 6'd61);
					send_barcode(left, 61, left + 130);
				end
				5: begin
					left = $urandom_range(30);
					configure(12'(left), 12'd4095, 6'd0);
					send_barcode(left, 0, left + 10);
				end
				6: begin
					// largest register value
					configure(12'd0, 12'd4095, 6'd63);
					send_barcode(0, 63, 130);
				end
				default: begin
					if (line_no != 8 && $urandom_range(9) == 0) begin
						n = $urandom_range(80, 20);
						send_noise(n);
					end else begin
						mw = $urandom_range(3, 1);
						left = $urandom_range(30);
						right = left + BARCODE_MODULES * mw;
						if ($urandom_range(5) == 0)
							right = right - $urandom_range(40);
						n = left + BARCODE_MODULES * mw + $urandom_range(5);
						if (line_no != 8 && $urandom_range(7) == 0)
							n = $urandom_range(n, 1);
						configure(12'(left), 12'(right), 6'(mw));
						// long hold-off so the decoder backs up into its input
						if (line_no == 8)
							hold_left = HOLD_CYCLES;
						send_barcode(left, mw, n);
					end
					random_pixels += n;
				end
			endcase
			line_no++;
		end while (!(random_pixels >= RANDOM_PIXELS && line_no > 8));

		// drain and finish
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("ean8_scanline_decoder_top_test OK");
		else
			$display("ean8_scanline_decoder_top_test NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/e8sd_pkg.sv
rtl/e8sd_code_match.sv
rtl/ean8_scanline_decoder_top.sv
dv/ean8_digit_tracker_pkg.sv
dv/ean8_scanline_decoder_top_test.sv
